// File: src/fegd_pkg.sv
// ----------------------------------------------------------------------------
// fegd_pkg
// Widths, constants and the quarter-wave cosine table builder for the
// flat-earth GPS distance block.
// ----------------------------------------------------------------------------
package fegd_pkg;

	localparam int LAT_W  = 31;
	localparam int LON_W  = 32;
	localparam int DIST_W = 33;

	localparam int COS_DEPTH = 1024;
	localparam int COS_W     = 16;

	localparam longint unsigned HALF_PI_Q30     = 64'd1686629713;
	localparam longint unsigned CM_PER_UNIT_Q32 = 64'd4773123977;
	localparam longint unsigned DEG90_UNITS     = 64'd900000000;
	localparam longint unsigned DEG180_UNITS    = 64'd1800000000;

	localparam int K_W    = 33;
	localparam int MEAN_W = 31;
	localparam int M_W    = 30;
	localparam int IDX_W  = $clog2(COS_DEPTH + 1);

	// reciprocal of 90 deg scaled by table depth, for the index estimate
	localparam int              QC_SH = 40;
	localparam longint unsigned QC    = (longint'(COS_DEPTH) << QC_SH) / DEG90_UNITS;
	localparam int              QC_W  = $clog2(QC + 1);
	localparam int              PQ_W  = M_W + QC_W + 1;

	localparam longint unsigned N_MAX = DEG90_UNITS * COS_DEPTH + DEG90_UNITS / 2;
	localparam int              N_W   = $clog2(N_MAX + 1);

	localparam int DLAT_W = 31;
	localparam int DLON_W = 32;
	localparam int DY_W   = 32;
	localparam int T_W    = 32;
	localparam int DX_W   = 33;
	localparam int SUM_W  = 67;
	localparam int ROOT_W = 35;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 2;

	typedef logic [COS_W-1:0] cos_table_t [0:COS_DEPTH];

	// |cos| of entry i, Q1.15, Taylor series to x^16/16!
	function automatic logic [COS_W-1:0] cos_entry(longint unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned e;
		longint          sum;
		x    = HALF_PI_Q30 * i / COS_DEPTH;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		sum  = longint'(term);
		term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		e = (longint'(sum) + (64'd1 << 14)) >> 15;
		if (e > 64'd32768) begin
			e = 64'd32768;
		end
		return COS_W'(e);
	endfunction

	function automatic cos_table_t build_cos_table();
		cos_table_t tbl;
		for (int i = 0; i <= COS_DEPTH; i++) begin
			tbl[i] = cos_entry(longint'(i));
		end
		return tbl;
	endfunction

endpackage

// File: src/fegd_in_if.sv
// ----------------------------------------------------------------------------
// fegd_in_if
// Point-pair channel: valid/ready with two GPS points as payload.
// ----------------------------------------------------------------------------
interface fegd_in_if;
	import fegd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] first_latitude;
	logic signed [LON_W-1:0] first_longitude;
	logic signed [LAT_W-1:0] second_latitude;
	logic signed [LON_W-1:0] second_longitude;

	modport source (
		output valid, first_latitude, first_longitude, second_latitude, second_longitude,
		input  ready
	);
	modport sink (
		input  valid, first_latitude, first_longitude, second_latitude, second_longitude,
		output ready
	);
endinterface

// File: src/fegd_out_if.sv
// ----------------------------------------------------------------------------
// fegd_out_if
// Distance channel: valid/ready with the distance in centimeters as payload.
// ----------------------------------------------------------------------------
interface fegd_out_if;
	import fegd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance_cm;

	modport source (output valid, distance_cm, input ready);
	modport sink (input valid, distance_cm, output ready);
endinterface

// File: src/flat_earth_gps_distance_top.sv
// ----------------------------------------------------------------------------
// flat_earth_gps_distance_top
// Equirectangular distance between two GPS points, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one point pair per cycle while ready is high and returns the distance
// in centimeters, saturated at 2^33-1. Eleven front stages form the mean
// latitude, the cosine table index (reciprocal estimate plus one correction),
// the registered cosine ROM read and the scaled differences and squares; the
// integer square root then takes 35 stages, one root bit per stage. A two-entry
// output buffer lets one more word in while a result is stalled; ready drops
// only when both entries are full.
module flat_earth_gps_distance_top (
	input  logic       clk,
	input  logic       arst_n,
	fegd_in_if.sink    point_in,
	fegd_out_if.source dist_out
);
	import fegd_pkg::*;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_stage_t;

	localparam cos_table_t COS_TABLE = build_cos_table();

	function automatic sq_stage_t sq_step(sq_stage_t a);
		sq_stage_t          r;
		logic [REM_W+1:0]   cur;
		logic [REM_W+1:0]   trial;
		cur   = {a.rem, a.rad[RAD_W-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		r.rad = a.rad << 2;
		if (cur >= trial) begin
			r.rem  = REM_W'(cur - trial);
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = REM_W'(cur);
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic sq_v_s [ROOT_W];

	logic signed [LAT_W:0]   lat_sum_s1;
	logic signed [LAT_W:0]   dlat_raw_s1;
	logic signed [LON_W:0]   dlon_raw_s1;
	logic [MEAN_W-1:0]       mean_s2;
	logic [DLAT_W-1:0]       dlat_s2;
	logic [DLON_W-1:0]       dlon_s2, dlon_s3, dlon_s4, dlon_s5, dlon_s6, dlon_s7;
	logic [M_W-1:0]          m_s3;
	logic [DY_W-1:0]         dy_s3, dy_s4, dy_s5, dy_s6, dy_s7, dy_s8, dy_s9;
	logic [IDX_W-1:0]        q0_s4, q0_s5;
	logic [N_W-1:0]          n_s4, n_s5, p_s5;
	logic [IDX_W-1:0]        idx_s6;
	logic [COS_W-1:0]        c_s7;
	logic [T_W-1:0]          t_s8;
	logic [DX_W-1:0]         dx_s9;
	logic [2*DX_W-1:0]       dx2_s10;
	logic [2*DY_W-1:0]       dy2_s10;
	logic [SUM_W-1:0]        sum_s11;
	sq_stage_t               sq_s [ROOT_W];
	sq_stage_t               sq_init;

	logic                    out_v_q, skid_v_q;
	logic [DIST_W-1:0]       out_d_q, skid_d_q;
	logic                    v_last;
	logic [DIST_W-1:0]       dist_last;

	logic [LAT_W:0]          lat_sum_abs;
	logic [LAT_W:0]          dlat_abs;
	logic [LON_W:0]          dlon_abs;
	logic [DLAT_W+K_W:0]     dy_prod;
	logic [PQ_W-1:0]         q_prod;
	logic [N_W:0]            corr;
	logic [DLON_W+COS_W:0]   t_prod;
	logic [63:0]             dx_prod;
	logic [ROOT_W-1:0]       root_last;

	assign en             = !skid_v_q;
	assign point_in.ready = !skid_v_q;

	always_comb begin
		lat_sum_abs = lat_sum_s1[LAT_W] ? (~lat_sum_s1) + 1'b1 : lat_sum_s1;
		dlat_abs    = dlat_raw_s1[LAT_W] ? (~dlat_raw_s1) + 1'b1 : dlat_raw_s1;
		dlon_abs    = dlon_raw_s1[LON_W] ? (~dlon_raw_s1) + 1'b1 : dlon_raw_s1;
		dy_prod     = (DLAT_W+K_W+1)'(dlat_s2) * (DLAT_W+K_W+1)'(CM_PER_UNIT_Q32)
			+ (DLAT_W+K_W+1)'(64'd1 << 31);
		q_prod      = PQ_W'(m_s3) * PQ_W'(QC) + PQ_W'(64'd1 << (QC_SH - 1));
		corr        = {1'b0, n_s5} - {1'b0, p_s5};
		t_prod      = (DLON_W+COS_W+1)'(dlon_s7) * (DLON_W+COS_W+1)'(c_s7)
			+ (DLON_W+COS_W+1)'(64'd1 << 14);
		// dx scaling wraps at 64 bits
		dx_prod     = 64'(t_s8) * 64'(CM_PER_UNIT_Q32) + 64'(64'd1 << 31);
		sq_init     = '{rad: {(RAD_W-SUM_W)'(0), sum_s11}, rem: '0, root: '0};
		root_last   = sq_s[ROOT_W-1].root;
		v_last      = sq_v_s[ROOT_W-1];
		dist_last   = (root_last[ROOT_W-1:DIST_W] != '0) ? '1 : root_last[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
			for (int j = 0; j < ROOT_W; j++) begin
				sq_v_s[j] <= 1'b0;
			end
		end else if (en) begin
			v_s1  <= point_in.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			sq_v_s[0] <= v_s11;
			for (int j = 1; j < ROOT_W; j++) begin
				sq_v_s[j] <= sq_v_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_sum_s1  <= (LAT_W+1)'(point_in.first_latitude)
				+ (LAT_W+1)'(point_in.second_latitude);
			dlat_raw_s1 <= (LAT_W+1)'(point_in.first_latitude)
				- (LAT_W+1)'(point_in.second_latitude);
			dlon_raw_s1 <= (LON_W+1)'(point_in.first_longitude)
				- (LON_W+1)'(point_in.second_longitude);

			mean_s2 <= lat_sum_abs[LAT_W:1];
			dlat_s2 <= dlat_abs[DLAT_W-1:0];
			dlon_s2 <= dlon_abs[DLON_W-1:0];

			// fold past 90 deg; only |cos| is needed
			m_s3    <= (MEAN_W'(mean_s2) > MEAN_W'(DEG90_UNITS))
				? M_W'(MEAN_W'(DEG180_UNITS) - mean_s2) : mean_s2[M_W-1:0];
			dy_s3   <= dy_prod[32 +: DY_W];
			dlon_s3 <= dlon_s2;

			q0_s4   <= q_prod[QC_SH +: IDX_W];
			n_s4    <= N_W'(m_s3) * N_W'(COS_DEPTH) + N_W'(DEG90_UNITS / 2);
			dlon_s4 <= dlon_s3;
			dy_s4   <= dy_s3;

			p_s5    <= N_W'(q0_s4) * N_W'(DEG90_UNITS);
			n_s5    <= n_s4;
			q0_s5   <= q0_s4;
			dlon_s5 <= dlon_s4;
			dy_s5   <= dy_s4;

			if (corr[N_W]) begin
				idx_s6 <= q0_s5 - 1'b1;
			end else if (corr[N_W-1:0] >= N_W'(DEG90_UNITS)) begin
				idx_s6 <= q0_s5 + 1'b1;
			end else begin
				idx_s6 <= q0_s5;
			end
			dlon_s6 <= dlon_s5;
			dy_s6   <= dy_s5;

			c_s7    <= COS_TABLE[idx_s6];
			dlon_s7 <= dlon_s6;
			dy_s7   <= dy_s6;

			t_s8    <= t_prod[15 +: T_W];
			dy_s8   <= dy_s7;

			dx_s9   <= DX_W'(dx_prod[63:32]);
			dy_s9   <= dy_s8;

			dx2_s10 <= (2*DX_W)'(dx_s9) * (2*DX_W)'(dx_s9);
			dy2_s10 <= (2*DY_W)'(dy_s9) * (2*DY_W)'(dy_s9);

			sum_s11 <= SUM_W'(dx2_s10) + SUM_W'(dy2_s10);

			sq_s[0] <= sq_step(sq_init);
			for (int j = 1; j < ROOT_W; j++) begin
				sq_s[j] <= sq_step(sq_s[j-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (dist_out.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (out_v_q && !dist_out.ready) begin
			if (v_last) begin
				skid_v_q <= 1'b1;
			end
		end else begin
			out_v_q <= v_last;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (dist_out.ready) begin
				out_d_q <= skid_d_q;
			end
		end else if (out_v_q && !dist_out.ready) begin
			if (v_last) begin
				skid_d_q <= dist_last;
			end
		end else begin
			out_d_q <= dist_last;
		end
	end

	assign dist_out.valid       = out_v_q;
	assign dist_out.distance_cm = out_d_q;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held with empty output register");

	a_stall_captures: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !dist_out.ready && v_last && !skid_v_q) |=> skid_v_q)
		else $error("stalled result not captured in skid buffer");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (idx_s6 <= IDX_W'(COS_DEPTH)))
		else $error("cosine index beyond table");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (c_s7 <= COS_W'(32768)))
		else $error("cosine entry above one");

endmodule

// File: sim/flat_earth_gps_distance_top_test.sv
// ----------------------------------------------------------------------------
// flat_earth_gps_distance_top_test
// Self-checking test of the flat-earth GPS distance block: directed corner
// pairs, then random point pairs, with random idling on both channels except
// during one steady run. Every result is checked in order against a datapath predictor.
// ----------------------------------------------------------------------------
module flat_earth_gps_distance_top_test;
	import fegd_pkg::*;

	logic clk;
	logic arst_n;

	fegd_in_if  point_in ();
	fegd_out_if dist_out ();

	flat_earth_gps_distance_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.point_in (point_in.sink),
		.dist_out (dist_out.source)
	);

	localparam longint unsigned K_Q32 = 64'd4773123977;
	localparam logic [DIST_W-1:0] DIST_SAT = '1;

	logic [DIST_W-1:0] dist_expected [$];
	logic [COS_W-1:0]  cos_lut [0:COS_DEPTH];
	int                mismatches;
	bit                sink_steady;
	bit                src_steady;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// own cosine table, Taylor series to x^16/16!
	function automatic logic [COS_W-1:0] cos_value(longint unsigned i);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned e;
		longint          acc;
		x    = 64'd1686629713 * i / COS_DEPTH;
		x2   = (x * x) >> 30;
		term = 64'd1 << 30;
		acc  = longint'(term);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		e = (unsigned'(acc) + (64'd1 << 14)) >> 15;
		if (e > 64'd32768) begin
			e = 64'd32768;
		end
		return COS_W'(e);
	endfunction

	function automatic logic [DIST_W-1:0] distance_of(logic [LAT_W-1:0] la1,
			logic [LON_W-1:0] lo1, logic [LAT_W-1:0] la2, logic [LON_W-1:0] lo2);
		longint          s1;
		longint          s2;
		longint          t1;
		longint          t2;
		longint          v;
		longint unsigned m;
		longint unsigned idx;
		longint unsigned dlat;
		longint unsigned dlon;
		longint unsigned t;
		longint unsigned dx;
		longint unsigned dy;
		logic [127:0]    sq;
		logic [127:0]    cand;
		longint unsigned r;
		s1 = longint'($signed(la1));
		s2 = longint'($signed(la2));
		t1 = longint'($signed(lo1));
		t2 = longint'($signed(lo2));
		v  = s1 + s2;
		m  = ((v < 0) ? -v : v) >> 1;
		m  = m % 64'd1800000000;
		if (m > 64'd900000000) begin
			m = 64'd1800000000 - m;
		end
		idx  = (m * COS_DEPTH + 64'd450000000) / 64'd900000000;
		v    = s1 - s2;
		dlat = (v < 0) ? -v : v;
		v    = t1 - t2;
		dlon = (v < 0) ? -v : v;
		dy   = (dlat * K_Q32 + (64'd1 << 31)) >> 32;
		t    = (dlon * cos_lut[idx] + 64'd16384) >> 15;
		dx   = (t * K_Q32 + (64'd1 << 31)) >> 32;
		sq   = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
		r    = 0;
		for (int b = 34; b >= 0; b--) begin
			cand = 128'(r | (64'd1 << b));
			if (cand * cand <= sq) begin
				r = r | (64'd1 << b);
			end
		end
		if (r > 64'h1_FFFF_FFFF) begin
			return DIST_SAT;
		end
		return DIST_W'(r);
	endfunction

	task automatic send_pair(logic [LAT_W-1:0] la1, logic [LON_W-1:0] lo1,
			logic [LAT_W-1:0] la2, logic [LON_W-1:0] lo2);
		while (!src_steady && $urandom_range(99) < 26) begin
			point_in.valid <= 1'b0;
			@(posedge clk);
		end
		point_in.valid            <= 1'b1;
		point_in.first_latitude   <= la1;
		point_in.first_longitude  <= lo1;
		point_in.second_latitude  <= la2;
		point_in.second_longitude <= lo2;
		dist_expected.push_back(distance_of(la1, lo1, la2, lo2));
		@(posedge clk);
		while (!point_in.ready) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [LAT_W-1:0] rand_lat(bit wild);
		if (wild) begin
			return LAT_W'($urandom);
		end
		return LAT_W'($signed($urandom_range(1800000000)) - 900000000);
	endfunction

	function automatic logic [LON_W-1:0] rand_lon(bit wild);
		longint v;
		if (wild) begin
			return $urandom;
		end
		v = longint'($urandom_range(2000000000)) + longint'($urandom_range(1600000000));
		return LON_W'(v - 64'd1800000000);
	endfunction

	task automatic wait_drained();
		point_in.valid <= 1'b0;
		while (dist_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_corners();
		send_pair('0, '0, '0, '0);
		send_pair(31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0);
		send_pair(31'sd0, 32'sd1800000000, 31'sd0, -32'sd1800000000);
		send_pair(31'sd450000000, 32'sd1799999999, 31'sd450000000, -32'sd1799999999);
		send_pair(31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
		send_pair({1'b0, {30{1'b1}}}, {1'b0, {31{1'b1}}}, {1'b1, 30'b0}, {1'b1, 31'b0});
		send_pair({1'b1, 30'b0}, {1'b1, 31'b0}, {1'b1, 30'b0}, {1'b0, {31{1'b1}}});
		send_pair('1, '1, '1, '1);
		send_pair(31'sd487654321, 32'sd23456789, 31'sd487654400, 32'sd23456700);
		send_pair(31'sd1000000000, 32'sd10, 31'sd1000000000, -32'sd10);
		send_pair(-31'sd1000000000, 32'sd100000, 31'sd100, -32'sd100000);
		send_pair(31'sd899999999, 32'sd5, 31'sd900000000, 32'sd6);
		send_pair(31'sd1, 32'sd1, 31'sd0, 32'sd0);
	endtask

	task automatic test_random(int n, bit steady);
		bit               wild;
		logic [LAT_W-1:0] a;
		logic [LON_W-1:0] b;
		src_steady  = steady;
		sink_steady = steady;
		for (int i = 0; i < n; i++) begin
			wild = ($urandom_range(9) == 0);
			a    = rand_lat(wild);
			b    = rand_lon(wild);
			if ($urandom_range(2) == 0) begin
				send_pair(a, b, a + LAT_W'($signed($urandom_range(20000)) - 10000),
					b + LON_W'($signed($urandom_range(20000)) - 10000));
			end else begin
				send_pair(a, b, rand_lat(wild), rand_lon(wild));
			end
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	always @(posedge clk) begin
		dist_out.ready <= sink_steady || ($urandom_range(99) >= 26);
		if (arst_n && dist_out.valid && dist_out.ready) begin
			if (dist_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected word: distance_cm=%0d", dist_out.distance_cm);
				end
			end else begin
				if (dist_out.distance_cm !== dist_expected[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("distance_cm mismatch: expected %0d actual %0d",
							dist_expected[0], dist_out.distance_cm);
					end
				end
				void'(dist_expected.pop_front());
			end
		end
	end

	initial begin
		mismatches                = 0;
		sink_steady               = 1'b0;
		src_steady                = 1'b0;
		arst_n                    = 1'b0;
		point_in.valid            = 1'b0;
		point_in.first_latitude   = '0;
		point_in.first_longitude  = '0;
		point_in.second_latitude  = '0;
		point_in.second_longitude = '0;
		dist_out.ready            = 1'b0;
		for (int i = 0; i <= COS_DEPTH; i++) begin
			cos_lut[i] = cos_value(longint'(i));
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_random(700, 1'b0);
		wait_drained();
		test_random(200, 1'b1);
		test_random(700, 1'b0);
		wait_drained();
		repeat (60) @(posedge clk);
		if (mismatches == 0 && dist_expected.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: flat_earth_gps_distance_top.f
src/fegd_pkg.sv
src/fegd_in_if.sv
src/fegd_out_if.sv
src/flat_earth_gps_distance_top.sv
sim/flat_earth_gps_distance_top_test.sv
